// File: sv/isap_pkg.sv
// ISAP-A-128 package: types, codes, constants and helper functions (rotation, byte mask, padding).
// No dependencies; used by the channel interfaces, the round unit and the top level.
package isap_pkg;

    localparam int unsigned RoundsPerPerm = 12;
    localparam int unsigned RndW          = 4;
    localparam logic [RndW-1:0] RndFirst  = RndW'(12 - RoundsPerPerm);

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_AD    = 2'd1;
    localparam logic [1:0] REQ_MSG   = 2'd2;

    localparam logic [1:0] KIND_CT  = 2'd0;
    localparam logic [1:0] KIND_TAG = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    localparam logic [0:0] CFG_KEY_HIGH = 1'd0;
    localparam logic [0:0] CFG_KEY_LOW  = 1'd1;

    localparam logic [7:0]  RndByte = 8'(RoundsPerPerm);
    localparam logic [63:0] IvTail  = {8'h00, 8'd128, 8'd64, 8'd1,
                                       RndByte, RndByte, RndByte, RndByte};
    localparam logic [63:0] IvKe = {8'h03, IvTail[55:0]};
    localparam logic [63:0] IvKa = {8'h02, IvTail[55:0]};
    localparam logic [63:0] IvA  = {8'h01, IvTail[55:0]};
    localparam logic [63:0] PadWord = {8'h80, 56'd0};

    typedef logic [63:0] t_state [5];

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] nonce_high;
        logic [63:0] nonce_low;
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        last_block;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] cipher_word;
        logic [3:0]  cipher_bytes;
        logic [63:0] tag_high;
        logic [63:0] tag_low;
        logic        last_result;
    } t_rsp;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] top_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < n) m[63-8*b -: 8] = 8'hff;
        end
        top_mask = m;
    endfunction

    function automatic logic [63:0] pad_word(input logic [3:0] n);
        logic [63:0] p;
        p = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) == n) p[63-8*b -: 8] = 8'h80;
        end
        pad_word = p;
    endfunction

endpackage

// File: sv/isap_req_if.sv
// Request channel: valid/ready handshake carrying one request item.
// Depends on isap_pkg.
interface isap_req_if;
    import isap_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/isap_rsp_if.sv
// Result channel: valid/ready handshake carrying one result item.
// Depends on isap_pkg.
interface isap_rsp_if;
    import isap_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/isap_round.sv
// One Ascon round, combinational; the shared unit of the core.
// Depends on isap_pkg.
module isap_round (
    input  logic [isap_pkg::RndW-1:0] i_rnd,
    input  logic [63:0]               i_s0,
    input  logic [63:0]               i_s1,
    input  logic [63:0]               i_s2,
    input  logic [63:0]               i_s3,
    input  logic [63:0]               i_s4,
    output logic [63:0]               o_s0,
    output logic [63:0]               o_s1,
    output logic [63:0]               o_s2,
    output logic [63:0]               o_s3,
    output logic [63:0]               o_s4
);
    import isap_pkg::*;
    logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
    logic [7:0]  rc;

    always_comb begin
        rc = {4'hf - 4'(i_rnd), 4'(i_rnd)};
        x0 = i_s0 ^ i_s4;
        x4 = i_s4 ^ i_s3;
        x2 = i_s2 ^ {56'd0, rc} ^ i_s1;
        x1 = i_s1;
        x3 = i_s3;
        t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
        x0 = x0 ^ t1; x1 = x1 ^ t2; x2 = x2 ^ t3; x3 = x3 ^ t4; x4 = x4 ^ t0;
        x1 = x1 ^ x0; x0 = x0 ^ x4; x3 = x3 ^ x2; x2 = ~x2;
        o_s0 = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
        o_s1 = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
        o_s2 = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
        o_s3 = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
        o_s4 = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
    end
endmodule

// File: sv/isap_a128_aead_encrypt_core.sv
// ISAP-A-128 authenticated encryption core (encrypt direction).
// Depends on isap_pkg, isap_req_if, isap_rsp_if and isap_round.
//
// Usage: write the key through the config port (index 0 = key_high,
// index 1 = key_low) while idle. Send a start item with the nonce, then
// associated-data items, then message items; mark the last of each with
// last_block. Each message item returns one ciphertext item; the final one
// also returns a tag item.
// Timing: one shared Ascon round unit does one round per cycle while a
// permutation runs. A permutation is RoundsPerPerm (12) rounds followed by
// one dispatch step. A start item costs 130 permutations, an associated-data
// block 1-2 permutations, a message block 2-4. A final message block adds
// the MAC re-key and final permutation (130 more). An error is answered
// from idle without a permutation.
// The core takes one item at a time; i_req.ready is low while it works
// or while a result waits in the output register.
// Reset (synchronous, active low) clears both states, the phase and the
// key. A stalled receiver holds the result register and the core waits.
module isap_a128_aead_encrypt_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    isap_req_if.sink      i_req,
    isap_rsp_if.source    o_rsp,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_wdata
);
    import isap_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_PERM    = 4'd1;  // run rounds on work state
    localparam logic [3:0] S_DISPAT  = 4'd2;  // decide next micro step
    localparam logic [3:0] S_OUT     = 4'd3;  // wait for result handshake

    // micro steps
    localparam logic [3:0] M_RK_INIT = 4'd0;
    localparam logic [3:0] M_RK_BIT  = 4'd1;
    localparam logic [3:0] M_SE_DONE = 4'd2;
    localparam logic [3:0] M_MAC_INI = 4'd3;
    localparam logic [3:0] M_AD      = 4'd4;
    localparam logic [3:0] M_AD_PAD  = 4'd5;
    localparam logic [3:0] M_EMPTYAD = 4'd6;
    localparam logic [3:0] M_KS      = 4'd7;
    localparam logic [3:0] M_CT_ABS  = 4'd8;
    localparam logic [3:0] M_CT_PAD  = 4'd9;
    localparam logic [3:0] M_TAG_RK  = 4'd10;
    localparam logic [3:0] M_TAG_BIT = 4'd11;
    localparam logic [3:0] M_TAG_FIN = 4'd12;
    localparam logic [3:0] M_DONE    = 4'd13;

    // operation phase
    localparam logic [1:0] P_IDLE    = 2'd0;
    localparam logic [1:0] P_START   = 2'd1;
    localparam logic [1:0] P_AD      = 2'd2;
    localparam logic [1:0] P_MSG     = 2'd3;

    logic [3:0]      r_st, n_st;
    logic [3:0]      r_step, n_step;
    logic [1:0]      r_phase, n_phase;
    logic [63:0]     r_key_hi, r_key_lo;
    logic [63:0]     r_enc [5];
    logic [63:0]     n_enc [5];
    logic [63:0]     r_mac [5];
    logic [63:0]     n_mac [5];
    logic [63:0]     r_w [5];
    logic [63:0]     n_w [5];
    logic [RndW-1:0] r_rnd, n_rnd;
    logic [6:0]      r_bit, n_bit;
    logic [127:0]    r_y, n_y;
    logic [63:0]     r_data, n_data;
    logic [3:0]      r_n, n_n;
    logic            r_last, n_last;
    logic            r_tagpend, n_tagpend;
    t_rsp            r_rsp, n_rsp;
    logic            r_rv, n_rv;
    logic [63:0]     rnd_o [5];
    logic [63:0]     ct;
    logic [3:0]      cnt;
    // nonce kept apart since r_y shifts out during re-key
    logic [63:0]     r_nonce_hi_w, r_nonce_lo_w;

    isap_round u_round (
        .i_rnd(r_rnd),
        .i_s0(r_w[0]), .i_s1(r_w[1]), .i_s2(r_w[2]), .i_s3(r_w[3]), .i_s4(r_w[4]),
        .o_s0(rnd_o[0]), .o_s1(rnd_o[1]), .o_s2(rnd_o[2]), .o_s3(rnd_o[3]),
        .o_s4(rnd_o[4])
    );

    assign i_req.ready   = (r_st == S_IDLE) && !r_rv;
    assign o_rsp.valid   = r_rv;
    assign o_rsp.payload = r_rsp;

    always_comb begin
        cnt = (i_req.payload.byte_count > 4'd8) ? 4'd8 : i_req.payload.byte_count;
        if (!i_req.payload.last_block) cnt = 4'd8;
    end

    assign ct = (r_data ^ r_w[0]) & top_mask(r_n);

    always_comb begin
        n_st = r_st; n_step = r_step; n_phase = r_phase;
        n_enc = r_enc; n_mac = r_mac; n_w = r_w; n_rnd = r_rnd;
        n_bit = r_bit; n_y = r_y; n_data = r_data; n_n = r_n; n_last = r_last;
        n_tagpend = r_tagpend; n_rsp = r_rsp; n_rv = r_rv;
        if (r_rv && o_rsp.ready) begin
            n_rv = 1'b0;
        end
        case (r_st)
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_data = i_req.payload.data_word;
                    n_n    = cnt;
                    n_last = i_req.payload.last_block;
                    n_rnd  = RndFirst;
                    if (i_req.payload.req_type == REQ_START) begin
                        n_y = {i_req.payload.nonce_high, i_req.payload.nonce_low};
                        n_w[0] = r_key_hi; n_w[1] = r_key_lo; n_w[2] = IvKe;
                        n_w[3] = '0; n_w[4] = '0;
                        n_bit = '0; n_step = M_RK_INIT; n_st = S_PERM;
                    end else if (i_req.payload.req_type == REQ_AD
                                 && (r_phase == P_START || r_phase == P_AD)) begin
                        n_w = r_mac;
                        n_w[0] = r_mac[0] ^ (i_req.payload.last_block
                            ? ((i_req.payload.data_word & top_mask(cnt)) | pad_word(cnt))
                            : i_req.payload.data_word);
                        n_step = (i_req.payload.last_block && cnt == 4'd8) ? M_AD_PAD : M_AD;
                        n_st = S_PERM;
                    end else if (i_req.payload.req_type == REQ_MSG
                                 && (r_phase == P_START || r_phase == P_MSG)) begin
                        if (r_phase == P_START) begin
                            n_w = r_mac; n_w[0] = r_mac[0] ^ PadWord;
                            n_step = M_EMPTYAD;
                        end else begin
                            n_w = r_enc; n_step = M_KS;
                        end
                        n_st = S_PERM;
                    end else begin
                        n_rsp = '{kind: KIND_ERR, cipher_word: '0, cipher_bytes: '0,
                                  tag_high: '0, tag_low: '0, last_result: 1'b1};
                        n_rv = 1'b1;
                    end
                end
            end
            S_PERM: begin
                n_w = rnd_o;
                n_rnd = r_rnd + 1'b1;
                if (r_rnd == RndW'(11)) n_st = S_DISPAT;
            end
            S_DISPAT: begin
                n_rnd = RndFirst;
                n_st = S_PERM;
                case (r_step)
                    M_RK_INIT, M_RK_BIT, M_TAG_RK, M_TAG_BIT: begin
                        // absorb one bit of y into word 0, advance
                        n_w[0] = r_w[0] ^ {r_y[127], 63'd0};
                        n_y = {r_y[126:0], 1'b0};
                        n_bit = r_bit + 1'b1;
                        if (r_bit == 7'd127) begin
                            n_step = (r_step == M_RK_INIT || r_step == M_RK_BIT)
                                     ? M_SE_DONE : M_TAG_FIN;
                        end else begin
                            n_step = (r_step == M_RK_INIT || r_step == M_RK_BIT)
                                     ? M_RK_BIT : M_TAG_BIT;
                        end
                    end
                    M_SE_DONE: begin
                        // hold the nonce in enc words 3/4 and set the MAC init
                        n_enc[0] = r_w[0]; n_enc[1] = r_w[1]; n_enc[2] = r_w[2];
                        n_enc[3] = r_nonce_hi_w; n_enc[4] = r_nonce_lo_w;
                        n_w[0] = r_nonce_hi_w; n_w[1] = r_nonce_lo_w; n_w[2] = IvA;
                        n_w[3] = '0; n_w[4] = '0;
                        n_step = M_MAC_INI;
                    end
                    M_MAC_INI: begin
                        n_mac = r_w;
                        n_st = S_IDLE;
                        n_phase = P_START;
                    end
                    M_AD: begin
                        n_mac = r_w;
                        n_st = S_IDLE;
                        if (r_last) begin
                            n_mac[4] = r_w[4] ^ 64'd1; n_phase = P_MSG;
                        end else begin
                            n_phase = P_AD;
                        end
                    end
                    M_AD_PAD: begin
                        n_w[0] = r_w[0] ^ PadWord;
                        n_step = M_AD;
                    end
                    M_EMPTYAD: begin
                        n_mac = r_w; n_mac[4] = r_w[4] ^ 64'd1;
                        n_phase = P_MSG;
                        n_w = r_enc;
                        n_step = M_KS;
                    end
                    M_KS: begin
                        n_enc = r_w;
                        n_rsp = '{kind: KIND_CT, cipher_word: ct, cipher_bytes: r_n,
                                  tag_high: '0, tag_low: '0, last_result: !r_last};
                        n_rv = 1'b1;
                        n_w = r_mac;
                        n_w[0] = r_mac[0] ^ (r_last
                            ? ((r_n == 4'd8) ? ct : (ct | pad_word(r_n))) : ct);
                        n_step = (r_last && r_n == 4'd8) ? M_CT_PAD : M_CT_ABS;
                    end
                    M_CT_PAD: begin
                        n_w[0] = r_w[0] ^ PadWord;
                        n_step = M_CT_ABS;
                    end
                    M_CT_ABS: begin
                        n_mac = r_w;
                        if (r_last) begin
                            n_y = {r_w[0], r_w[1]};
                            n_w[0] = r_key_hi; n_w[1] = r_key_lo; n_w[2] = IvKa;
                            n_w[3] = '0; n_w[4] = '0;
                            n_bit = '0; n_step = M_TAG_RK;
                        end else begin
                            n_st = S_OUT; n_tagpend = 1'b0;
                        end
                    end
                    M_TAG_FIN: begin
                        n_w[0] = r_w[0]; n_w[1] = r_w[1];
                        n_w[2] = r_mac[2]; n_w[3] = r_mac[3]; n_w[4] = r_mac[4];
                        n_step = M_DONE;
                    end
                    M_DONE: begin
                        n_mac = r_w;
                        n_phase = P_IDLE;
                        n_tagpend = 1'b1;
                        n_st = S_OUT;
                    end
                    default: n_st = S_IDLE;
                endcase
            end
            S_OUT: begin
                if (!n_rv) begin
                    if (r_tagpend) begin
                        n_rsp = '{kind: KIND_TAG, cipher_word: '0, cipher_bytes: '0,
                                  tag_high: r_mac[0], tag_low: r_mac[1], last_result: 1'b1};
                        n_rv = 1'b1;
                        n_tagpend = 1'b0;
                    end
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_req.valid && i_req.ready
            && i_req.payload.req_type == REQ_START) begin
            r_nonce_hi_w <= i_req.payload.nonce_high;
            r_nonce_lo_w <= i_req.payload.nonce_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_step <= M_RK_INIT; r_phase <= P_IDLE;
            r_rv <= 1'b0; r_tagpend <= 1'b0;
            r_key_hi <= '0; r_key_lo <= '0;
            for (int k = 0; k < 5; k++) begin
                r_enc[k] <= '0; r_mac[k] <= '0;
            end
        end else begin
            r_st <= n_st; r_step <= n_step; r_phase <= n_phase;
            r_rv <= n_rv; r_tagpend <= n_tagpend;
            r_enc <= n_enc; r_mac <= n_mac;
            if (i_cfg_we && i_cfg_index == CFG_KEY_HIGH) r_key_hi <= i_cfg_wdata;
            if (i_cfg_we && i_cfg_index == CFG_KEY_LOW)  r_key_lo <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w; r_rnd <= n_rnd; r_bit <= n_bit; r_y <= n_y;
        r_data <= n_data; r_n <= n_n; r_last <= n_last; r_rsp <= n_rsp;
    end
endmodule
